### design/assert_macros.svh
// Assertion macros shared by the page allocator RTL.
// Included by every module that carries concurrent checks; needs a port named clock and reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Condition that must never be seen at a rising clock edge.
`define ASSERT_NEVER(label, expr, msg) \
   `ASSERT_CLK(label, !(expr), msg)

`endif

### design/pbca_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the page bitmap allocator.
// No dependencies; imported by the page map and the top level.
package pbca_pkg;

   // Width of every address, base and byte count word.
   localparam int WORD_W = 32;
   // Width of the serial bit position counter.
   localparam int BIT_CNT_W = 5;

   // Packed payload widths of the two stream channels.
   localparam int REQ_DATA_W = 64;
   localparam int RSP_DATA_W = 40;

   // Request kinds carried on req_tuser.
   localparam logic FUNC_ALLOC = 1'b0;
   localparam logic FUNC_FREE  = 1'b1;

   // Commands from the sequencer to the page map.
   typedef struct packed {
      logic set;
      logic clr;
   } map_cmd_type;

endpackage

### design/pbca_serial_add.sv
`timescale 1ns / 1ps
// Bit-serial full adder with a stored carry, one bit per cycle while step is high, LSB first.
// Standalone; used by the top level for the window test and the granted address.
module pbca_serial_add (
   input  logic clock,
   input  logic step,      // advance one bit this cycle
   input  logic first,     // first bit of a word: carry comes from cin
   input  logic cin,
   input  logic a,
   input  logic b,
   output logic sum,
   output logic carry      // carry out of the last bit stepped
);

   logic carry_ff;
   logic carry_in;
   logic c;

   // Carry into this bit position.
   assign c        = first ? cin : carry_ff;
   assign sum      = a ^ b ^ c;
   assign carry_in = (a & b) | (a & c) | (b & c);
   assign carry    = carry_ff;

   // The carry holds while no bit is stepped.
   always_ff @(posedge clock) begin
      if (step) begin
         carry_ff <= carry_in;
      end
   end

endmodule

### design/pbca_page_map.sv
`timescale 1ns / 1ps
// Used-page bitmap with a range window: tests a run for overlap, sets or clears it.
// Depends on pbca_pkg and assert_macros.svh.
`include "assert_macros.svh"
module pbca_page_map
   import pbca_pkg::*;
#(
   parameter int POOL_PAGES = 16,
   parameter int CNT_W      = 5
) (
   input  logic            clock,
   input  logic            reset,
   input  map_cmd_type     cmd,
   input  logic [CNT_W-1:0] lo,    // first page of the run
   input  logic [CNT_W:0]   hi,    // one past the last page of the run
   output logic            fit     // no page of the run is used
);

   logic [POOL_PAGES-1:0] map_ff;
   logic [POOL_PAGES-1:0] map_in;
   logic [POOL_PAGES-1:0] win;

   // One compare pair per page builds the run window.
   always_comb begin
      for (int p = 0; p < POOL_PAGES; p++) begin
         win[p] = ((CNT_W+1)'(p) >= {1'b0, lo}) && ((CNT_W+1)'(p) < hi);
      end
   end

   assign fit = (map_ff & win) == '0;

   // Mark or release the pages under the window.
   always_comb begin
      map_in = map_ff;
      if (cmd.set) begin
         map_in = map_ff | win;
      end else if (cmd.clr) begin
         map_in = map_ff & ~win;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         map_ff <= '0;
      end else begin
         map_ff <= map_in;
      end
   end

   // An allocation and a release never land in the same cycle.
   `ASSERT_NEVER(a_set_clr_excl, cmd.set && cmd.clr, "page map got set and clear together")
   // A release never marks a page used.
   `ASSERT_CLK(a_clr_no_new, cmd.clr |=> ((map_ff & ~$past(map_ff)) == '0), "clear set a page")
   // An allocation always takes at least one page.
   `ASSERT_CLK(a_set_grows, cmd.set |=> ($countones(map_ff) > $countones($past(map_ff))),
      "set took no page")

endmodule

### design/page_bitmap_contiguous_allocator.sv
`timescale 1ns / 1ps
// Top level of the first-fit page allocator: stream ports, sequencer, serial datapath.
// Depends on pbca_pkg, pbca_serial_add, pbca_page_map and assert_macros.svh.
//
//   channel | direction | contents
//   req     | in        | tdata: byte_count, address; tuser: func
//   rsp     | out       | tdata: ok, granted_address, in_window
//   csr     | in        | pool_base, written by csr_we
//
// Address and base pass one bit a cycle through a serial adder; the byte count shifts alongside.
// A free then goes to the decision and the result; an allocation adds the first-fit
// scan (one start page a cycle, up to POOL_PAGES) and a serial add for the granted address.
// Reset is synchronous and marks all pages free; pool_base resets to zero.
// A new request is taken while a finished result still waits on rsp.
`include "assert_macros.svh"
module page_bitmap_contiguous_allocator
   import pbca_pkg::*;
#(
   parameter int POOL_PAGES = 16,
   parameter int PAGE_SHIFT = 12
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // [31:0] byte_count, [63:32] address
   input  logic                  req_tuser,   // [0] func
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // [0] ok, [32:1] granted_address,
                                              // [33] in_window, [39:34] zero
   input  logic                  csr_we,
   input  logic [WORD_W-1:0]     csr_wdata    // pool_base
);

   localparam int CNT_W = $clog2(POOL_PAGES + 1);
   localparam logic [BIT_CNT_W-1:0] LO_POS   = BIT_CNT_W'(PAGE_SHIFT);
   localparam logic [BIT_CNT_W-1:0] HI_POS   = BIT_CNT_W'(PAGE_SHIFT + CNT_W);
   localparam logic [BIT_CNT_W-1:0] LAST_BIT = BIT_CNT_W'(WORD_W - 1);
   localparam logic [CNT_W:0]       POOL_N   = (CNT_W+1)'(POOL_PAGES);

   // Sequencer states.
   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_SER    = 3'd1;
   localparam logic [2:0] S_DECIDE = 3'd2;
   localparam logic [2:0] S_SCAN   = 3'd3;
   localparam logic [2:0] S_ADD    = 3'd4;
   localparam logic [2:0] S_DONE   = 3'd5;

   logic [2:0]            state_ff, state_in;
   logic [BIT_CNT_W-1:0]  bit_cnt_ff, bit_cnt_in;
   logic [WORD_W-1:0]     base_ff;
   logic [WORD_W-1:0]     addr_sr_ff, addr_sr_in;
   logic [WORD_W-1:0]     base_sr_ff, base_sr_in;
   logic [WORD_W-1:0]     bytes_sr_ff, bytes_sr_in;
   logic [WORD_W-1:0]     res_sr_ff, res_sr_in;
   logic                  func_ff, func_in;
   logic                  base_nz_ff, base_nz_in;
   logic                  bytes_nz_ff, bytes_nz_in;
   logic                  low_nz_ff, low_nz_in;
   logic                  bhi_ff, bhi_in;
   logic                  dhi_ff, dhi_in;
   logic [CNT_W-1:0]      bfield_ff, bfield_in;
   logic [CNT_W-1:0]      dfield_ff, dfield_in;
   logic [CNT_W-1:0]      pages_ff, pages_in;
   logic [CNT_W-1:0]      idx_ff, idx_in;
   logic                  ok_ff, ok_in;
   logic                  inwin_ff, inwin_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic                  in_lo, in_mid, in_hi;
   logic                  add_step, add_first, add_cin, add_a, add_b, add_sum, add_carry;
   logic [CNT_W:0]        pages_calc;
   logic [CNT_W:0]        pages_free;
   logic [CNT_W+1:0]      free_sum;
   logic [CNT_W:0]        free_end;
   logic [CNT_W:0]        scan_hi;
   logic                  alloc_go;
   logic                  window_hit;
   logic                  map_fit;
   logic [CNT_W-1:0]      map_lo;
   logic [CNT_W:0]        map_hi;
   map_cmd_type           map_cmd;
   logic                  req_fire;
   logic                  rsp_free;
   logic [CNT_W:0]        bf_shift, df_shift, idx_shift;
   logic [WORD_W-1:0]     granted;

   // Pool base register; the user must write it only while idle, the block does not enforce it.
   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff <= '0;
      end else if (csr_we) begin
         base_ff <= csr_wdata;
      end
   end

   // Where the current serial bit sits relative to the page number field.
   assign in_lo  = bit_cnt_ff < LO_POS;
   assign in_mid = !in_lo && (bit_cnt_ff < HI_POS);
   assign in_hi  = !in_lo && !in_mid;

   // Serial adder: address minus base in the first pass, base plus offset in the last.
   assign add_step  = (state_ff == S_SER) || (state_ff == S_ADD);
   assign add_first = bit_cnt_ff == '0;
   assign add_cin   = state_ff == S_SER;
   assign add_a     = (state_ff == S_SER) ? addr_sr_ff[0] : base_sr_ff[0];
   assign add_b     = (state_ff == S_SER) ? ~base_sr_ff[0] : (in_mid & idx_ff[0]);

   pbca_serial_add u_add (
      .clock (clock),
      .step  (add_step),
      .first (add_first),
      .cin   (add_cin),
      .a     (add_a),
      .b     (add_b),
      .sum   (add_sum),
      .carry (add_carry)
   );

   // Page counts and run ends from the captured fields.
   assign pages_calc = {1'b0, bfield_ff} + (CNT_W+1)'(low_nz_ff);
   assign pages_free = bytes_nz_ff ? pages_calc : (CNT_W+1)'(1);
   assign free_sum   = {2'b00, dfield_ff} + {1'b0, pages_free};
   assign free_end   = (bhi_ff || (free_sum > {1'b0, POOL_N})) ? POOL_N : free_sum[CNT_W:0];
   assign scan_hi    = {1'b0, idx_ff} + {1'b0, pages_ff};
   assign alloc_go   = base_nz_ff && bytes_nz_ff && !bhi_ff && (pages_calc <= POOL_N);
   // The carry out of the subtraction is one when no borrow occurred.
   assign window_hit = base_nz_ff && add_carry && !dhi_ff && ({1'b0, dfield_ff} < POOL_N);

   // Page map commands.
   assign map_lo      = (state_ff == S_SCAN) ? idx_ff : dfield_ff;
   assign map_hi      = (state_ff == S_SCAN) ? scan_hi : free_end;
   assign map_cmd.set = (state_ff == S_SCAN) && map_fit;
   assign map_cmd.clr = (state_ff == S_DECIDE) && (func_ff == FUNC_FREE) && window_hit;

   pbca_page_map #(
      .POOL_PAGES (POOL_PAGES),
      .CNT_W      (CNT_W)
   ) u_map (
      .clock (clock),
      .reset (reset),
      .cmd   (map_cmd),
      .lo    (map_lo),
      .hi    (map_hi),
      .fit   (map_fit)
   );

   // Handshakes.
   assign req_tready = state_ff == S_IDLE;
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_free   = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // Shift helpers that stay legal for a one-bit field.
   assign bf_shift  = {bytes_sr_ff[0], bfield_ff};
   assign df_shift  = {add_sum, dfield_ff};
   assign idx_shift = {1'b0, idx_ff};
   assign granted   = ((func_ff == FUNC_ALLOC) && ok_ff) ? res_sr_ff : '0;

   // Sequencer and serial datapath.
   always_comb begin
      state_in     = state_ff;
      bit_cnt_in   = bit_cnt_ff;
      addr_sr_in   = addr_sr_ff;
      base_sr_in   = base_sr_ff;
      bytes_sr_in  = bytes_sr_ff;
      res_sr_in    = res_sr_ff;
      func_in      = func_ff;
      base_nz_in   = base_nz_ff;
      bytes_nz_in  = bytes_nz_ff;
      low_nz_in    = low_nz_ff;
      bhi_in       = bhi_ff;
      dhi_in       = dhi_ff;
      bfield_in    = bfield_ff;
      dfield_in    = dfield_ff;
      pages_in     = pages_ff;
      idx_in       = idx_ff;
      ok_in        = ok_ff;
      inwin_in     = inwin_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               bytes_sr_in = req_tdata[WORD_W-1:0];
               addr_sr_in  = req_tdata[REQ_DATA_W-1:WORD_W];
               base_sr_in  = base_ff;
               func_in     = req_tuser;
               bit_cnt_in  = '0;
               base_nz_in  = 1'b0;
               bytes_nz_in = 1'b0;
               low_nz_in   = 1'b0;
               bhi_in      = 1'b0;
               dhi_in      = 1'b0;
               state_in    = S_SER;
            end
         end
         S_SER: begin
            // One bit of each word a cycle; capture the page number fields.
            addr_sr_in  = addr_sr_ff >> 1;
            base_sr_in  = base_sr_ff >> 1;
            bytes_sr_in = bytes_sr_ff >> 1;
            base_nz_in  = base_nz_ff | base_sr_ff[0];
            bytes_nz_in = bytes_nz_ff | bytes_sr_ff[0];
            if (in_lo) begin
               low_nz_in = low_nz_ff | bytes_sr_ff[0];
            end
            if (in_mid) begin
               bfield_in = bf_shift[CNT_W:1];
               dfield_in = df_shift[CNT_W:1];
            end
            if (in_hi) begin
               bhi_in = bhi_ff | bytes_sr_ff[0];
               dhi_in = dhi_ff | add_sum;
            end
            bit_cnt_in = bit_cnt_ff + 1'b1;
            if (bit_cnt_ff == LAST_BIT) begin
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            inwin_in = window_hit;
            idx_in   = '0;
            pages_in = pages_calc[CNT_W-1:0];
            if (func_ff == FUNC_FREE) begin
               ok_in    = window_hit;
               state_in = S_DONE;
            end else if (alloc_go) begin
               state_in = S_SCAN;
            end else begin
               ok_in    = 1'b0;
               state_in = S_DONE;
            end
         end
         S_SCAN: begin
            // One candidate start page a cycle, lowest first.
            if (map_fit) begin
               ok_in      = 1'b1;
               base_sr_in = base_ff;
               bit_cnt_in = '0;
               state_in   = S_ADD;
            end else if (scan_hi == POOL_N) begin
               ok_in    = 1'b0;
               state_in = S_DONE;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         S_ADD: begin
            // Base plus page offset, one bit a cycle into the result register.
            base_sr_in = base_sr_ff >> 1;
            res_sr_in  = {add_sum, res_sr_ff[WORD_W-1:1]};
            if (in_mid) begin
               idx_in = idx_shift[CNT_W:1];
            end
            bit_cnt_in = bit_cnt_ff + 1'b1;
            if (bit_cnt_ff == LAST_BIT) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {(RSP_DATA_W-WORD_W-2)'(0), inwin_ff, granted, ok_ff};
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      bit_cnt_ff  <= bit_cnt_in;
      addr_sr_ff  <= addr_sr_in;
      base_sr_ff  <= base_sr_in;
      bytes_sr_ff <= bytes_sr_in;
      res_sr_ff   <= res_sr_in;
      func_ff     <= func_in;
      base_nz_ff  <= base_nz_in;
      bytes_nz_ff <= bytes_nz_in;
      low_nz_ff   <= low_nz_in;
      bhi_ff      <= bhi_in;
      dhi_ff      <= dhi_in;
      bfield_ff   <= bfield_in;
      dfield_ff   <= dfield_in;
      pages_ff    <= pages_in;
      idx_ff      <= idx_in;
      ok_ff       <= ok_in;
      inwin_ff    <= inwin_in;
      rsp_data_ff <= rsp_data_in;
   end

   // The scan only ever looks at whole runs inside the pool.
   `ASSERT_CLK(a_scan_range, (state_ff == S_SCAN) |->
      ((pages_ff != '0) && (scan_hi <= POOL_N)), "scan run outside pool")
   // A free result succeeds exactly when the address hits the window.
   `ASSERT_CLK(a_free_ok, ((state_ff == S_DONE) && (func_ff == FUNC_FREE)) |->
      (ok_ff == inwin_ff), "free status disagrees with window test")
   // A failed result never carries an address.
   `ASSERT_CLK(a_fail_zero, (rsp_valid_ff && !rsp_data_ff[0]) |->
      (rsp_data_ff[WORD_W:1] == '0), "failed result with nonzero address")

endmodule

### bench/tb_top.sv
`timescale 1ns / 1ps
// Self-checking bench for the first-fit page allocator: stream driver, stream monitor,
// a bit-accurate model of the page map and pool window, and random traffic with idling.
// Depends on pbca_pkg and page_bitmap_contiguous_allocator.
module tb_top
   import pbca_pkg::*;
;

   localparam int POOL_PAGES = 16;
   localparam int PAGE_SHIFT = 12;
   localparam int PAGE_BYTES = 1 << PAGE_SHIFT;
   localparam int POOL_BYTES = POOL_PAGES * PAGE_BYTES;
   localparam int RANDOM_PHASES = 9;
   localparam int ITEMS_PER_PHASE = 150;
   localparam int LONG_HOLD_CYCLES = 400;
   localparam int TAIL_CYCLES = 200;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int REPORT_LIMIT = 10;

   typedef struct packed {
      logic            func;
      logic [WORD_W-1:0] byte_count;
      logic [WORD_W-1:0] address;
   } page_request_type;

   typedef struct packed {
      logic            ok;
      logic [WORD_W-1:0] granted;
      logic            in_window;
   } page_reply_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  req_tuser = FUNC_ALLOC;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_we = 1'b0;
   logic [WORD_W-1:0]     csr_wdata = '0;

   // Model state: pool base register and one used bit per page.
   logic [WORD_W-1:0]     pool_base_model = '0;
   logic [POOL_PAGES-1:0] page_map_model = '0;

   page_request_type pending_requests[$];
   page_reply_type   awaited_replies[$];
   page_request_type next_request;
   page_reply_type   oldest_reply;

   logic        req_offering = 1'b0;
   int unsigned req_wait = 0;
   int unsigned rsp_wait = 0;
   int unsigned rsp_hold_left = 0;
   int unsigned hold_requests = 0;
   int unsigned hold_served = 0;
   logic        sender_no_idle = 1'b0;
   logic        receiver_no_idle = 1'b0;
   int unsigned quiet_cycles = 0;

   int unsigned mismatches = 0;
   int unsigned requests_sent = 0;
   int unsigned replies_seen = 0;
   int unsigned grants_made = 0;
   int unsigned frees_done = 0;
   int unsigned refusals = 0;
   int unsigned window_hits = 0;
   int unsigned base_settings = 0;

   page_bitmap_contiguous_allocator #(
      .POOL_PAGES(POOL_PAGES),
      .PAGE_SHIFT(PAGE_SHIFT)
   ) i_dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),    // [31:0] byte_count, [63:32] address
      .req_tuser(req_tuser),    // [0] func
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),    // [0] ok, [32:1] granted_address, [33] in_window
      .csr_we(csr_we),
      .csr_wdata(csr_wdata)     // pool_base
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Computes the reply to one request and updates the modeled page map.
   function automatic page_reply_type model_request(logic func, logic [WORD_W-1:0] count,
                                                    logic [WORD_W-1:0] where);
      page_reply_type reply;
      logic [WORD_W:0] window_top;
      logic [31:0] run;
      int unsigned pages;
      int unsigned first;
      reply = '0;
      // The window top is taken one bit wider so it never wraps.
      window_top = {1'b0, pool_base_model} + (WORD_W + 1)'(POOL_BYTES);
      reply.in_window = (pool_base_model != 0) && (where >= pool_base_model) &&
                        ({1'b0, where} < window_top);
      pages = (count >> PAGE_SHIFT) + (count[PAGE_SHIFT-1:0] != 0);
      if (func == FUNC_ALLOC) begin
         // First fit: the lowest start page whose whole run is free.
         if (pool_base_model != 0 && count != 0 && pages <= POOL_PAGES) begin
            for (int p = 0; p + pages <= POOL_PAGES; p++) begin
               run = ((32'd1 << pages) - 32'd1) << p;
               if (!reply.ok && (page_map_model & run[POOL_PAGES-1:0]) == '0) begin
                  page_map_model |= run[POOL_PAGES-1:0];
                  reply.ok = 1'b1;
                  reply.granted = pool_base_model + WORD_W'(p << PAGE_SHIFT);
               end
            end
         end
         if (reply.ok) grants_made++;
      end else if (reply.in_window) begin
         // A zero count frees one page; the run stops at the last pool page.
         first = (where - pool_base_model) >> PAGE_SHIFT;
         if (count == 0) pages = 1;
         if (first + pages > POOL_PAGES) pages = POOL_PAGES - first;
         run = ((32'd1 << pages) - 32'd1) << first;
         page_map_model &= ~run[POOL_PAGES-1:0];
         reply.ok = 1'b1;
         frees_done++;
      end
      if (!reply.ok) refusals++;
      if (reply.in_window) window_hits++;
      return reply;
   endfunction

   function automatic int unsigned draw_idle(logic no_idle);
      return no_idle ? 0 : $urandom_range(0, 14);
   endfunction

   function automatic void report_mismatch(string text);
      mismatches++;
      if (mismatches <= REPORT_LIMIT) $display("Mismatch at %0t ns: %s", $realtime, text);
   endfunction

   // Request driver: offers queued requests, with a random gap after each transfer.
   always @(posedge clock) begin
      if (reset) begin
         req_offering = 1'b0;
         req_wait = 0;
      end else begin
         if (req_offering && req_tready) begin
            awaited_replies.push_back(model_request(req_tuser, req_tdata[31:0],
                                                    req_tdata[63:32]));
            requests_sent++;
            req_offering = 1'b0;
            req_wait = draw_idle(sender_no_idle);
         end
         if (!req_offering) begin
            if (req_wait != 0) begin
               req_wait--;
            end else if (pending_requests.size() != 0) begin
               next_request = pending_requests.pop_front();
               req_tuser <= next_request.func;
               req_tdata <= {next_request.address, next_request.byte_count};
               req_offering = 1'b1;
            end
         end
      end
      req_tvalid <= req_offering;
   end

   // Reply monitor: checks each transfer against the oldest prediction and
   // stalls the result channel at random, or for a long hold when asked.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_wait = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            replies_seen++;
            if (awaited_replies.size() == 0) begin
               report_mismatch($sformatf("unexpected reply ok=%0b granted=%h in_window=%0b",
                                         rsp_tdata[0], rsp_tdata[32:1], rsp_tdata[33]));
            end else begin
               oldest_reply = awaited_replies.pop_front();
               if (rsp_tdata[0] !== oldest_reply.ok ||
                   rsp_tdata[32:1] !== oldest_reply.granted ||
                   rsp_tdata[33] !== oldest_reply.in_window) begin
                  report_mismatch($sformatf(
                     {"reply %0d expected ok=%0b granted=%h in_window=%0b, ",
                      "got ok=%0b granted=%h in_window=%0b"},
                     replies_seen, oldest_reply.ok, oldest_reply.granted, oldest_reply.in_window,
                     rsp_tdata[0], rsp_tdata[32:1], rsp_tdata[33]));
               end
            end
            rsp_wait = draw_idle(receiver_no_idle);
         end
         if (hold_served != hold_requests) begin
            hold_served++;
            rsp_hold_left = LONG_HOLD_CYCLES;
         end
         if (rsp_hold_left != 0) begin
            rsp_hold_left--;
            rsp_tready <= 1'b0;
         end else if (rsp_wait != 0) begin
            rsp_wait--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Watchdog: too long without any transfer ends the run.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Watchdog expired after %0d cycles without a transfer.", quiet_cycles);
         $display("FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic queue_request(logic func, logic [WORD_W-1:0] count, logic [WORD_W-1:0] where);
      page_request_type item;
      item.func = func;
      item.byte_count = count;
      item.address = where;
      pending_requests.push_back(item);
   endtask

   // Mostly small allocations and frees inside the window, plus wide noise.
   task automatic queue_random_request();
      int unsigned pick;
      logic [WORD_W-1:0] count;
      logic [WORD_W-1:0] where;
      pick = $urandom_range(0, 99);
      where = $urandom();
      if (pick < 40) begin
         count = (pick < 34) ? $urandom_range(1, 4 * PAGE_BYTES)
                             : $urandom_range(1, POOL_BYTES + PAGE_BYTES);
         if ($urandom_range(0, 1) == 1)
            where = pool_base_model + $urandom_range(0, POOL_BYTES - 1);
         queue_request(FUNC_ALLOC, count, where);
      end else if (pick < 85) begin
         case ($urandom_range(0, 4))
            0: count = '0;
            1, 2: count = $urandom_range(1, 2 * PAGE_BYTES);
            3: count = $urandom_range(1, POOL_BYTES + PAGE_BYTES);
            default: count = $urandom();
         endcase
         where = pool_base_model + $urandom_range(0, POOL_BYTES - 1);
         queue_request(FUNC_FREE, count, where);
      end else if (pick < 93) begin
         count = ($urandom_range(0, 3) == 0) ? '0 : $urandom();
         queue_request(FUNC_ALLOC, count, where);
      end else begin
         queue_request(FUNC_FREE, $urandom(), where);
      end
   endtask

   // Waits until every queued request has been sent and answered.
   task automatic wait_for_drain();
      @(negedge clock);
      while (pending_requests.size() != 0 || req_offering || awaited_replies.size() != 0)
         @(negedge clock);
   endtask

   // The block is idle whenever this is called, so the model follows at once.
   task automatic set_pool_base(logic [WORD_W-1:0] value);
      @(posedge clock);
      csr_wdata <= value;
      csr_we <= 1'b1;
      @(posedge clock);
      csr_we <= 1'b0;
      pool_base_model = value;
      base_settings++;
   endtask

   initial begin
      logic [WORD_W-1:0] base;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Pool still disabled from reset: both operations are refused.
      queue_request(FUNC_ALLOC, 32'd4096, 32'h0000_0000);
      queue_request(FUNC_FREE, 32'd0, 32'h0000_0000);
      wait_for_drain();

      // Sizing, first fit, window edges and clipping in a mid-range pool.
      set_pool_base(32'h8000_0000);
      queue_request(FUNC_ALLOC, 32'd0, 32'h8000_0000);
      queue_request(FUNC_ALLOC, 32'd1, 32'h0000_0000);
      queue_request(FUNC_ALLOC, 32'd4096, 32'hFFFF_FFFF);
      queue_request(FUNC_ALLOC, 32'd4097, 32'h8000_FFFF);
      queue_request(FUNC_ALLOC, 32'h0001_0001, 32'h8000_0000);
      queue_request(FUNC_ALLOC, 32'hFFFF_FFFF, 32'h8001_0000);
      queue_request(FUNC_ALLOC, 32'h0001_0000, 32'h7FFF_FFFF);
      queue_request(FUNC_FREE, 32'd0, 32'h8000_1000);
      queue_request(FUNC_ALLOC, 32'd4096, 32'h8000_1000);
      queue_request(FUNC_FREE, 32'd4096, 32'h7FFF_FFFF);
      queue_request(FUNC_FREE, 32'd4096, 32'h8001_0000);
      queue_request(FUNC_FREE, 32'hFFFF_FFFF, 32'h8000_FFFF);
      queue_request(FUNC_FREE, 32'h0000_2000, 32'h8000_3000);
      queue_request(FUNC_FREE, 32'h0001_0000, 32'h8000_0000);
      queue_request(FUNC_ALLOC, 32'h0001_0000, 32'h8000_0000);
      queue_request(FUNC_FREE, 32'd0, 32'h8000_5000);
      queue_request(FUNC_ALLOC, 32'h0000_2000, 32'h8000_5000);
      queue_request(FUNC_ALLOC, 32'h0000_1000, 32'h8000_5000);
      wait_for_drain();

      // A window that runs past the top of the address space; grants wrap.
      set_pool_base(32'hFFFF_8000);
      queue_request(FUNC_FREE, 32'h0001_0000, 32'hFFFF_8000);
      queue_request(FUNC_ALLOC, 32'h0000_9000, 32'hFFFF_8000);
      queue_request(FUNC_ALLOC, 32'h0000_1000, 32'h0000_0000);
      queue_request(FUNC_FREE, 32'd1, 32'hFFFF_FFFF);
      queue_request(FUNC_FREE, 32'd0, 32'h0000_0000);
      wait_for_drain();

      // Random traffic over a series of pool bases, extremes included.
      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         case (ph)
            0: base = 32'h0010_0000;
            1: base = 32'hFFFF_FFFF;
            2: base = 32'h0000_0000;
            3: base = $urandom() & 32'hFFFF_F000;
            4: base = 32'h0000_0001;
            5: base = $urandom();
            6: base = 32'hFFFF_0000;
            7: base = 32'h8000_0000;
            default: base = $urandom() | 32'h0000_0001;
         endcase
         set_pool_base(base);
         sender_no_idle = (ph == 3 || ph == 6);
         receiver_no_idle = (ph == 3 || ph == 7);
         repeat (ITEMS_PER_PHASE) queue_random_request();
         // Hold the result channel long enough for the block to back up.
         if (ph == 0 || ph == 6) hold_requests++;
         wait_for_drain();
      end

      repeat (TAIL_CYCLES) @(posedge clock);
      $display("Sent %0d requests over %0d pool base settings: %0d grants, %0d frees,",
               requests_sent, base_settings, grants_made, frees_done);
      $display("%0d refusals; %0d window hits; %0d long result stalls; %0d mismatches.",
               refusals, window_hits, hold_served, mismatches);
      if (mismatches == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

### sim.f
+incdir+design
design/pbca_pkg.sv
design/pbca_serial_add.sv
design/pbca_page_map.sv
design/page_bitmap_contiguous_allocator.sv
bench/tb_top.sv
